// ===== sv/slwm_pkg.sv =====
// ----------------------------------------------------------------------------
// slwm_pkg
// Shared types, constants and helpers of the service latency window monitor.
// ----------------------------------------------------------------------------
package slwm_pkg;

  localparam int unsigned NUM_SERVICES = 3;
  localparam int unsigned SVC_W = (NUM_SERVICES > 1) ? $clog2(NUM_SERVICES) : 1;
  localparam int unsigned IDX_W = $clog2(NUM_SERVICES + 1);

  localparam logic [31:0] THRESHOLD_RESET = 32'd100;
  localparam logic [31:0] MAX32           = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX_DEPTH       = 16'hFFFF;
  localparam logic [1:0]  SUMMARY_ROW     = 2'd3;
  localparam int unsigned PHASE_BITS      = 32;

  typedef enum logic [2:0] {
    FUNC_BEGIN  = 3'd0,
    FUNC_ENTER  = 3'd1,
    FUNC_LEAVE  = 3'd2,
    FUNC_BLOCK  = 3'd3,
    FUNC_FINISH = 3'd4
  } slwm_func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] attempt_id;
    logic [1:0]  service;
    logic [47:0] now_ms;
    logic [47:0] window_start_ms;
    logic [7:0]  phase;
    logic [47:0] span_start_ms;
    logic [47:0] span_end_ms;
    logic [7:0]  span_tag;
  } slwm_in_t;

  typedef struct packed {
    logic [31:0] report_id;
    logic [1:0]  row;
    logic [31:0] max_gap_ms;
    logic [31:0] max_call_ms;
    logic [31:0] call_count;
    logic [31:0] over_count;
    logic [47:0] elapsed_ms;
    logic [31:0] context_mask;
    logic [7:0]  longest_span_tag;
    logic [31:0] longest_span_ms;
    logic        last;
  } slwm_out_t;

  // result of the shared span unit
  typedef struct packed {
    logic        lt;    // b below a
    logic [47:0] diff;  // b - a, wrapping
    logic [31:0] len;   // saturated duration
  } slwm_span_t;

  function automatic logic [31:0] phase_bit(input logic [7:0] phase);
    logic [31:0] m;
    m = '0;
    if (32'(phase) < PHASE_BITS) begin
      m = 32'd1 << phase[4:0];
    end
    return m;
  endfunction

endpackage

// ===== sv/slwm_span_unit.sv =====
// ----------------------------------------------------------------------------
// slwm_span_unit
// Shared 48-bit subtract and compare unit with a saturated 32-bit duration.
// ----------------------------------------------------------------------------
module slwm_span_unit
  import slwm_pkg::*;
(
  input  logic        clk_i,
  input  logic [47:0] a_i,
  input  logic [47:0] b_i,
  output slwm_span_t  res_o
);

  logic [48:0] sub;
  slwm_span_t  res_d;
  slwm_span_t  res_q;

  always_comb begin
    sub        = {1'b0, b_i} - {1'b0, a_i};
    res_d.lt   = sub[48];
    res_d.diff = sub[47:0];
    if (sub[48] || (|sub[47:32])) begin
      res_d.len = MAX32;
    end else begin
      res_d.len = sub[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== sv/service_latency_window_monitor_core.sv =====
// ----------------------------------------------------------------------------
// service_latency_window_monitor_core
// Per-service latency statistics over a measurement window.
// ----------------------------------------------------------------------------
// Requests come in on in_valid_i / in_stall_o with an slwm_in_t payload and
// are taken one at a time: in_stall_o stays high while the sequencer works
// on a request. All durations go through one shared subtract unit, one
// operation per cycle, so the cost is set by how many uses a request makes.
// While in_stall_o is high after acceptance the request is decoded and
// then, if it needs them, goes through the subtract steps: enter a gap
// step, leave an entry-time compare and a cost step, block a check, a
// start compare and a span step. A finish that is not ignored takes per
// service a launch and a gap step, plus a compare and a cost step while
// the service is entered, then the window length, then the result rows.
// A finish with the open window's id gives three service rows and a
// summary row (last high) on out_valid_o / out_stall_i. Results sit in an
// output register, so a new request is taken while the summary row still
// waits; a stall on the output holds the rows and the sequencer waits.
// cfg_we_i / cfg_wdata_i write the over threshold in any cycle.
// Reset clears all statistics, closes the window and sets the threshold
// to 100 ms.
// ----------------------------------------------------------------------------
module service_latency_window_monitor_core
  import slwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  slwm_in_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output slwm_out_t   out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_GAP,
    ST_CFROM,
    ST_COST,
    ST_BK_CHK,
    ST_BK_FROM,
    ST_BK_SPAN,
    ST_FN_LAUNCH,
    ST_WIN,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  slwm_in_t          item_q, item_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  row_q, row_d;
  logic              out_valid_q, out_valid_d;
  slwm_out_t         out_q, out_d;
  logic [31:0]       thr_q, thr_d;

  logic [31:0] gap_q   [NUM_SERVICES];
  logic [31:0] gap_d   [NUM_SERVICES];
  logic [31:0] cost_q  [NUM_SERVICES];
  logic [31:0] cost_d  [NUM_SERVICES];
  logic [31:0] count_q [NUM_SERVICES];
  logic [31:0] count_d [NUM_SERVICES];
  logic [31:0] over_q  [NUM_SERVICES];
  logic [31:0] over_d  [NUM_SERVICES];
  logic [15:0] nest_q  [NUM_SERVICES];
  logic [15:0] nest_d  [NUM_SERVICES];
  logic [47:0] enter_q [NUM_SERVICES];
  logic [47:0] enter_d [NUM_SERVICES];
  logic [47:0] last_q  [NUM_SERVICES];
  logic [47:0] last_d  [NUM_SERVICES];

  logic        active_q, active_d;
  logic [31:0] cur_id_q, cur_id_d;
  logic [47:0] start_q, start_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] best_q, best_d;
  logic [7:0]  tag_q, tag_d;
  logic [47:0] win_q, win_d;

  logic [47:0] ua, ub;
  slwm_span_t  ures;

  logic             in_acc;
  logic             svc_ok;
  logic [SVC_W-1:0] svc_idx;
  logic [SVC_W-1:0] cur;
  logic             is_fin;

  slwm_span_unit u_span (
    .clk_i (clk_i),
    .a_i   (ua),
    .b_i   (ub),
    .res_o (ures)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign svc_ok  = (32'(item_q.service) < NUM_SERVICES);
  assign svc_idx = SVC_W'(item_q.service);
  assign is_fin  = (item_q.func == FUNC_FINISH);
  // finish walks the services, enter and leave name one
  assign cur     = is_fin ? idx_q[SVC_W-1:0] : svc_idx;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    thr_d       = cfg_we_i ? cfg_wdata_i : thr_q;
    gap_d       = gap_q;
    cost_d      = cost_q;
    count_d     = count_q;
    over_d      = over_q;
    nest_d      = nest_q;
    enter_d     = enter_q;
    last_d      = last_q;
    active_d    = active_q;
    cur_id_d    = cur_id_q;
    start_d     = start_q;
    mask_d      = mask_q;
    best_d      = best_q;
    tag_d       = tag_q;
    win_d       = win_q;
    ua          = '0;
    ub          = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d  = in_req_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_d = ST_IDLE;
        unique case (item_q.func)
          FUNC_BEGIN: begin
            cur_id_d = item_q.attempt_id;
            start_d  = item_q.window_start_ms;
            mask_d   = phase_bit(item_q.phase);
            best_d   = '0;
            tag_d    = '0;
            active_d = 1'b1;
            for (int i = 0; i < NUM_SERVICES; i++) begin
              gap_d[i]   = '0;
              cost_d[i]  = '0;
              over_d[i]  = '0;
              count_d[i] = (nest_q[i] != '0) ? 32'd1 : 32'd0;
              last_d[i]  = item_q.window_start_ms;
            end
          end
          FUNC_ENTER: begin
            if (svc_ok) begin
              if (nest_q[svc_idx] != '0) begin
                if (nest_q[svc_idx] != MAX_DEPTH) begin
                  nest_d[svc_idx] = nest_q[svc_idx] + 16'd1;
                end
              end else begin
                nest_d[svc_idx]  = 16'd1;
                enter_d[svc_idx] = item_q.now_ms;
                if (active_q) begin
                  ua      = last_q[svc_idx];
                  ub      = item_q.now_ms;
                  state_d = ST_GAP;
                end
              end
            end
          end
          FUNC_LEAVE: begin
            if (svc_ok && (nest_q[svc_idx] != '0)) begin
              nest_d[svc_idx] = nest_q[svc_idx] - 16'd1;
              if ((nest_q[svc_idx] == 16'd1) && active_q) begin
                // which of entry time and window start is later
                ua      = enter_q[svc_idx];
                ub      = start_q;
                state_d = ST_CFROM;
              end
            end
          end
          FUNC_BLOCK: begin
            if (active_q) begin
              ua      = start_q;
              ub      = item_q.span_end_ms;
              state_d = ST_BK_CHK;
            end
          end
          FUNC_FINISH: begin
            if (active_q && (item_q.attempt_id == cur_id_q)) begin
              mask_d  = mask_q | phase_bit(item_q.phase);
              idx_d   = '0;
              state_d = ST_FN_LAUNCH;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_GAP: begin
        if (ures.len > gap_q[cur]) begin
          gap_d[cur] = ures.len;
        end
        if ((ures.len > thr_q) && (over_q[cur] != MAX32)) begin
          over_d[cur] = over_q[cur] + 32'd1;
        end
        last_d[cur] = item_q.now_ms;
        if (is_fin) begin
          if (nest_q[cur] != '0) begin
            ua      = enter_q[cur];
            ub      = start_q;
            state_d = ST_CFROM;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_FN_LAUNCH;
          end
        end else begin
          if (count_q[cur] != MAX32) begin
            count_d[cur] = count_q[cur] + 32'd1;
          end
          mask_d  = mask_q | phase_bit(item_q.phase);
          state_d = ST_IDLE;
        end
      end

      ST_CFROM: begin
        // lt set: entry time after window start
        ua      = ures.lt ? enter_q[cur] : start_q;
        ub      = item_q.now_ms;
        state_d = ST_COST;
      end

      ST_COST: begin
        if (ures.len > cost_q[cur]) begin
          cost_d[cur] = ures.len;
        end
        if (is_fin) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_FN_LAUNCH;
        end else begin
          mask_d  = mask_q | phase_bit(item_q.phase);
          state_d = ST_IDLE;
        end
      end

      ST_BK_CHK: begin
        if (ures.lt) begin
          // span ends before the window opened
          state_d = ST_IDLE;
        end else begin
          ua      = item_q.span_start_ms;
          ub      = start_q;
          state_d = ST_BK_FROM;
        end
      end

      ST_BK_FROM: begin
        ua      = ures.lt ? item_q.span_start_ms : start_q;
        ub      = item_q.span_end_ms;
        state_d = ST_BK_SPAN;
      end

      ST_BK_SPAN: begin
        if (ures.len > best_q) begin
          best_d = ures.len;
          tag_d  = item_q.span_tag;
        end
        state_d = ST_IDLE;
      end

      ST_FN_LAUNCH: begin
        if (idx_q == IDX_W'(NUM_SERVICES)) begin
          ua      = start_q;
          ub      = item_q.now_ms;
          state_d = ST_WIN;
        end else begin
          ua      = last_q[cur];
          ub      = item_q.now_ms;
          state_d = ST_GAP;
        end
      end

      ST_WIN: begin
        win_d    = ures.diff;
        active_d = 1'b0;
        row_d    = '0;
        state_d  = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.report_id = cur_id_q;
          if (row_q == IDX_W'(NUM_SERVICES)) begin
            out_d.row              = SUMMARY_ROW;
            out_d.elapsed_ms       = win_q;
            out_d.context_mask     = mask_q;
            out_d.longest_span_tag = tag_q;
            out_d.longest_span_ms  = best_q;
            out_d.last             = 1'b1;
            state_d                = ST_IDLE;
          end else begin
            out_d.row         = 2'(row_q);
            out_d.max_gap_ms  = gap_q[row_q[SVC_W-1:0]];
            out_d.max_call_ms = cost_q[row_q[SVC_W-1:0]];
            out_d.call_count  = count_q[row_q[SVC_W-1:0]];
            out_d.over_count  = over_q[row_q[SVC_W-1:0]];
            row_d             = row_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      idx_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      thr_q       <= THRESHOLD_RESET;
      for (int i = 0; i < NUM_SERVICES; i++) begin
        gap_q[i]   <= '0;
        cost_q[i]  <= '0;
        count_q[i] <= '0;
        over_q[i]  <= '0;
        nest_q[i]  <= '0;
        enter_q[i] <= '0;
        last_q[i]  <= '0;
      end
      active_q <= 1'b0;
      cur_id_q <= '0;
      start_q  <= '0;
      mask_q   <= '0;
      best_q   <= '0;
      tag_q    <= '0;
      win_q    <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      idx_q       <= idx_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      thr_q       <= thr_d;
      gap_q       <= gap_d;
      cost_q      <= cost_d;
      count_q     <= count_d;
      over_q      <= over_d;
      nest_q      <= nest_d;
      enter_q     <= enter_d;
      last_q      <= last_d;
      active_q    <= active_d;
      cur_id_q    <= cur_id_d;
      start_q     <= start_d;
      mask_q      <= mask_d;
      best_q      <= best_d;
      tag_q       <= tag_d;
      win_q       <= win_d;
    end
  end

endmodule
